// ----- rtl/core/triangular_point_smoother_core_macros.svh -----
// Assertion helpers used by the smoother datapath.
`ifndef TRIANGULAR_POINT_SMOOTHER_CORE_MACROS_SVH
`define TRIANGULAR_POINT_SMOOTHER_CORE_MACROS_SVH

// Same-cycle implication, clocked on aclk, off while aresetn is low.
`define TPS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off while aresetn is low.
`define TPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/tps_pkg.sv -----
package tps_pkg;

    localparam int RADIUS_W = 3;
    localparam int WEIGHT_W = 4;
    localparam int DIV_W    = 7;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 3'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MAC,
        ST_DIV_INIT,
        ST_DIV,
        ST_WRITE
    } tps_state_t;

    typedef struct packed {
        logic load;
        logic start_point;
        logic mac;
        logic div_init;
        logic div_step;
        logic write;
        logic next_point;
        logic finish;
    } tps_cmd_t;

    typedef struct packed {
        logic any_out;
        logic tap_last;
        logic div_last;
        logic out_free;
        logic more_points;
    } tps_status_t;

endpackage

// ----- rtl/core/tps_ctrl.sv -----
module tps_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  tps_pkg::tps_status_t status,
    output tps_pkg::tps_cmd_t    cmd
);

    tps_pkg::tps_state_t state_reg;
    tps_pkg::tps_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tps_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tps_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = tps_pkg::ST_DECIDE;
                end
            end
            tps_pkg::ST_DECIDE: begin
                state_next = status.any_out ? tps_pkg::ST_MAC : tps_pkg::ST_IDLE;
            end
            tps_pkg::ST_MAC: begin
                if (status.tap_last) begin
                    state_next = tps_pkg::ST_DIV_INIT;
                end
            end
            tps_pkg::ST_DIV_INIT: begin
                state_next = tps_pkg::ST_DIV;
            end
            tps_pkg::ST_DIV: begin
                if (status.div_last) begin
                    state_next = tps_pkg::ST_WRITE;
                end
            end
            tps_pkg::ST_WRITE: begin
                if (status.out_free) begin
                    state_next = status.more_points ? tps_pkg::ST_MAC : tps_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tps_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            tps_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            tps_pkg::ST_DECIDE: begin
                cmd.start_point = status.any_out;
                cmd.finish      = !status.any_out;
            end
            tps_pkg::ST_MAC: begin
                cmd.mac = 1'b1;
            end
            tps_pkg::ST_DIV_INIT: begin
                cmd.div_init = 1'b1;
            end
            tps_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            tps_pkg::ST_WRITE: begin
                cmd.write      = status.out_free;
                cmd.next_point = status.out_free && status.more_points;
                cmd.finish     = status.out_free && !status.more_points;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- rtl/core/tps_datapath.sv -----
`include "triangular_point_smoother_core_macros.svh"

module tps_datapath #(
    parameter int MAX_RADIUS  = 7,
    parameter int COORD_WIDTH = 24
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [tps_pkg::RADIUS_W-1:0]          cfg_wr_data,
    input  logic signed [COORD_WIDTH-1:0]         in_x,
    input  logic signed [COORD_WIDTH-1:0]         in_y,
    input  logic                                  in_end,
    input  tps_pkg::tps_cmd_t                     cmd,
    output tps_pkg::tps_status_t                  status,
    input  logic                                  m_tready,
    output logic                                  out_valid,
    output logic [COORD_WIDTH-1:0]                out_x,
    output logic [COORD_WIDTH-1:0]                out_y,
    output logic                                  out_final
);

    localparam int RW       = tps_pkg::RADIUS_W;
    localparam int WW       = tps_pkg::WEIGHT_W;
    localparam int WIN_DEPTH = 2 * MAX_RADIUS + 1;
    localparam int IDX_W    = $clog2(WIN_DEPTH);
    localparam int PS_W     = $clog2(WIN_DEPTH + 1);
    localparam int AGE_W    = ((IDX_W > RW) ? IDX_W : RW) + 2;
    localparam int ACC_W    = COORD_WIDTH + 7;
    localparam int NUM_W    = COORD_WIDTH + 6;
    localparam int PROD_W   = COORD_WIDTH + WW + 1;
    localparam int BIT_W    = $clog2(COORD_WIDTH);

    logic [RW-1:0]              radius_reg;
    logic [RW-1:0]              r_reg;
    logic [RW-1:0]              r_sat;
    logic                       end_reg;
    logic [PS_W-1:0]            ps_reg;
    logic [RW-1:0]              c_reg;
    logic [IDX_W-1:0]           tap_reg;
    logic signed [COORD_WIDTH-1:0] win_x_reg [WIN_DEPTH];
    logic signed [COORD_WIDTH-1:0] win_y_reg [WIN_DEPTH];
    logic signed [ACC_W-1:0]    acc_x_reg;
    logic signed [ACC_W-1:0]    acc_y_reg;
    logic [NUM_W-1:0]           num_x_reg;
    logic [NUM_W-1:0]           num_y_reg;
    logic                       neg_x_reg;
    logic                       neg_y_reg;
    logic [COORD_WIDTH-1:0]     q_x_reg;
    logic [COORD_WIDTH-1:0]     q_y_reg;
    logic [BIT_W-1:0]           bit_reg;
    logic                       out_valid_reg;
    logic [COORD_WIDTH-1:0]     out_x_reg;
    logic [COORD_WIDTH-1:0]     out_y_reg;
    logic                       out_final_reg;

    logic [AGE_W-1:0]           r_ext;
    logic [AGE_W-1:0]           c_ext;
    logic [AGE_W-1:0]           tap_ext;
    logic [AGE_W-1:0]           ps_ext;
    logic [AGE_W-1:0]           ps_m1;
    logic [AGE_W-1:0]           two_r;
    logic [AGE_W-1:0]           top_ext;
    logic signed [AGE_W-1:0]    age;
    logic [AGE_W-1:0]           age_clamp;
    logic [IDX_W-1:0]           sel_idx;
    logic [AGE_W-1:0]           tap_dist;
    logic [AGE_W-1:0]           weight_ext;
    logic [WW-1:0]              weight;
    logic signed [PROD_W-1:0]   prod_x;
    logic signed [PROD_W-1:0]   prod_y;
    logic [WW-1:0]              rp1;
    logic [2*WW-1:0]            d_full;
    logic [tps_pkg::DIV_W-1:0]  d_val;
    logic [ACC_W-1:0]           mag_x;
    logic [ACC_W-1:0]           mag_y;
    logic [NUM_W-1:0]           dsh;

    // Radius saturates to the window capacity
    always_comb begin
        if (int'(radius_reg) > MAX_RADIUS) begin
            r_sat = RW'(MAX_RADIUS);
        end else begin
            r_sat = radius_reg;
        end
    end

    always_comb begin
        r_ext   = AGE_W'(r_reg);
        c_ext   = AGE_W'(c_reg);
        tap_ext = AGE_W'(tap_reg);
        ps_ext  = AGE_W'(ps_reg);
        ps_m1   = ps_ext - AGE_W'(1);
        two_r   = r_ext << 1;
        top_ext = (ps_m1 < r_ext) ? ps_m1 : r_ext;

        age = $signed(c_ext + r_ext - tap_ext);
        if (age[AGE_W-1]) begin
            age_clamp = '0;
        end else if ($unsigned(age) > ps_m1) begin
            age_clamp = ps_m1;
        end else begin
            age_clamp = $unsigned(age);
        end
        sel_idx = age_clamp[IDX_W-1:0];

        tap_dist   = (tap_ext >= r_ext) ? (tap_ext - r_ext) : (r_ext - tap_ext);
        weight_ext = r_ext + AGE_W'(1) - tap_dist;
        weight     = weight_ext[WW-1:0];

        prod_x = win_x_reg[sel_idx] * $signed({1'b0, weight});
        prod_y = win_y_reg[sel_idx] * $signed({1'b0, weight});

        rp1    = WW'(r_reg) + WW'(1);
        d_full = rp1 * rp1;
        d_val  = d_full[tps_pkg::DIV_W-1:0];

        mag_x = acc_x_reg[ACC_W-1] ? (~acc_x_reg + ACC_W'(1)) : acc_x_reg;
        mag_y = acc_y_reg[ACC_W-1] ? (~acc_y_reg + ACC_W'(1)) : acc_y_reg;

        dsh = NUM_W'(d_val) << bit_reg;
    end

    always_comb begin
        status.any_out     = end_reg || (ps_ext >= r_ext + AGE_W'(1));
        status.tap_last    = (tap_ext == two_r);
        status.div_last    = (bit_reg == '0);
        status.out_free    = !out_valid_reg || m_tready;
        status.more_points = end_reg && (c_reg != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg    <= tps_pkg::RADIUS_RESET;
            ps_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                radius_reg <= cfg_wr_data;
            end
            if (cmd.load) begin
                ps_reg <= ps_reg + PS_W'(ps_reg != PS_W'(WIN_DEPTH));
            end else if (cmd.finish && end_reg) begin
                ps_reg <= '0;
            end
            if (cmd.write) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            win_x_reg[0] <= in_x;
            win_y_reg[0] <= in_y;
            for (int i = 1; i < WIN_DEPTH; i++) begin
                win_x_reg[i] <= win_x_reg[i-1];
                win_y_reg[i] <= win_y_reg[i-1];
            end
            r_reg   <= r_sat;
            end_reg <= in_end;
        end

        if (cmd.start_point) begin
            c_reg <= end_reg ? top_ext[RW-1:0] : r_reg;
        end else if (cmd.next_point) begin
            c_reg <= c_reg - RW'(1);
        end

        if (cmd.start_point || cmd.next_point) begin
            tap_reg   <= '0;
            acc_x_reg <= '0;
            acc_y_reg <= '0;
        end else if (cmd.mac) begin
            tap_reg   <= tap_reg + IDX_W'(1);
            acc_x_reg <= acc_x_reg + ACC_W'(prod_x);
            acc_y_reg <= acc_y_reg + ACC_W'(prod_y);
        end

        // Round half away from zero: divide |sum| + d/2, then restore the sign
        if (cmd.div_init) begin
            num_x_reg <= mag_x[NUM_W-1:0] + NUM_W'(d_val >> 1);
            num_y_reg <= mag_y[NUM_W-1:0] + NUM_W'(d_val >> 1);
            neg_x_reg <= acc_x_reg[ACC_W-1];
            neg_y_reg <= acc_y_reg[ACC_W-1];
            q_x_reg   <= '0;
            q_y_reg   <= '0;
            bit_reg   <= BIT_W'(COORD_WIDTH - 1);
        end else if (cmd.div_step) begin
            if (num_x_reg >= dsh) begin
                num_x_reg          <= num_x_reg - dsh;
                q_x_reg[bit_reg]   <= 1'b1;
            end
            if (num_y_reg >= dsh) begin
                num_y_reg          <= num_y_reg - dsh;
                q_y_reg[bit_reg]   <= 1'b1;
            end
            bit_reg <= bit_reg - BIT_W'(1);
        end

        if (cmd.write) begin
            out_x_reg     <= neg_x_reg ? (~q_x_reg + COORD_WIDTH'(1)) : q_x_reg;
            out_y_reg     <= neg_y_reg ? (~q_y_reg + COORD_WIDTH'(1)) : q_y_reg;
            out_final_reg <= end_reg && (c_reg == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_final = out_final_reg;

    `TPS_ASSERT_IMPL(a_write_into_free, cmd.write, (!out_valid_reg || m_tready), "result overwritten while stalled")
    `TPS_ASSERT_IMPL(a_mac_has_points, cmd.mac, (ps_reg != '0), "accumulating over an empty window")
    `TPS_ASSERT_IMPL(a_tap_in_kernel, cmd.mac, (tap_ext <= two_r), "tap beyond kernel length")
    `TPS_ASSERT_NEXT(a_load_no_output, cmd.load, (!cmd.write), "result written in the cycle after a load")

endmodule

// ----- rtl/core/triangular_point_smoother_core.sv -----
// Triangular point smoother. Each path point (x, y signed Q15.8 in s_tdata, s_tlast on the
// last point of a path) shifts into a window of the last 2*MAX_RADIUS+1 points. Once r+1
// points of a path are in, every point brings out one smoothed point lagging r behind; the
// point marked s_tlast flushes all remaining smoothed points of the path, the last one with
// m_tlast set. Each smoothed point is the (r+1-|j|)-weighted sum over j = -r..r, indices
// clamped to the path ends, divided by (r+1)^2 with round half away from zero. The radius r
// comes from cfg_wr_data (reset 1, saturated to MAX_RADIUS); write it only while idle.
// An input transaction is taken while idle and decoded in the cycle after. Each smoothed
// point then runs the tap-serial multiply-accumulate over its 2r+1 taps, a setup step and
// the bit-serial restoring divider, then moves into the output register once that register
// is free. A point that yields nothing goes straight back to idle after it is decoded.
// The output register lets a new input transaction in while the last result still waits
// on m_tready; a second result waits in the quotient registers while the controller holds.
module triangular_point_smoother_core #(
    parameter int MAX_RADIUS  = 7,
    parameter int COORD_WIDTH = 24
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    // Radius register write
    input  logic                                cfg_wr_en,
    input  logic [tps_pkg::RADIUS_W-1:0]        cfg_wr_data,

    // Path points in
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // point_x, point_y, zero pad to whole bytes
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]  s_tdata,
    input  logic                                s_tlast,

    // Smoothed points out
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // smooth_x, smooth_y, zero pad to whole bytes
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]  m_tdata,
    output logic                                m_tlast
);

    localparam int DATA_W = ((2 * COORD_WIDTH + 7) / 8) * 8;

    tps_pkg::tps_cmd_t    cmd;
    tps_pkg::tps_status_t status;
    logic [COORD_WIDTH-1:0] out_x;
    logic [COORD_WIDTH-1:0] out_y;

    // Sequence the load, accumulate, divide and write steps
    tps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Window, accumulators, divider and output register
    tps_datapath #(
        .MAX_RADIUS  (MAX_RADIUS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_x        ($signed(s_tdata[COORD_WIDTH-1:0])),
        .in_y        ($signed(s_tdata[2*COORD_WIDTH-1:COORD_WIDTH])),
        .in_end      (s_tlast),
        .cmd         (cmd),
        .status      (status),
        .m_tready    (m_tready),
        .out_valid   (m_tvalid),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_final   (m_tlast)
    );

    // Pack x low, y above it, zero the pad
    assign m_tdata = DATA_W'({out_y, out_x});

endmodule

// ----- verif/triangular_point_smoother_core_test.sv -----
`timescale 1ns / 100ps

module triangular_point_smoother_core_test;

    localparam int MAX_R     = 7;
    localparam int COORD_W   = 24;
    localparam int DATA_W    = ((2*COORD_W+7)/8)*8;
    localparam int WIN_DEPTH = 2*MAX_R + 1;
    localparam int RADIUS_W  = tps_pkg::RADIUS_W;

    // Worst case of one smoothed point plus margin; wait this long
    // after the last result before touching the radius or ending the run.
    localparam int SETTLE_CYCLES = 2*MAX_R + COORD_W + 30;
    // Receiver hold-off that backs the block up into its input.
    localparam int LONG_HOLD     = 600;
    localparam int RANDOM_ITEMS  = 450;
    localparam int TIMEOUT_NS    = 20_000_000;

    localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
    } path_point_t;

    // Receiver stall patterns.
    typedef enum {RX_OPEN, RX_COIN, RX_TRICKLE} rx_mode_t;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [RADIUS_W-1:0] cfg_wr_data = '0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata     = '0;   // point_x, point_y
    logic                s_tlast     = 1'b0; // path_end
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [DATA_W-1:0]   m_tdata;            // smooth_x, smooth_y
    logic                m_tlast;            // final_point
    logic                hold_req    = 1'b0;

    // Points waiting for the driver, and smoothed points the block still owes.
    path_point_t point_feed_q[$];
    path_point_t smooth_due_q[$];
    int          fed_count   = 0;
    int          taken_count = 0;
    int          fail_count  = 0;

    // Predictor state: window newest first, fill level of the current path, radius.
    logic signed [COORD_W-1:0] win_x [WIN_DEPTH];
    logic signed [COORD_W-1:0] win_y [WIN_DEPTH];
    int                        path_fill  = 0;
    logic [RADIUS_W-1:0]       radius_now = tps_pkg::RADIUS_RESET;

    // Driver and monitor working variables.
    int          burst_left = 0;
    int          gap_left   = 0;
    path_point_t next_pt;
    int          r_eff, top_c, i, c;
    path_point_t due_pt;
    int          hold_left  = 0;
    int          seg_left   = 0;
    bit          hold_done  = 1'b0;
    rx_mode_t    rx_mode    = RX_OPEN;

    triangular_point_smoother_core #(
        .MAX_RADIUS  (MAX_R),
        .COORD_WIDTH (COORD_W)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Divide with round to nearest, ties away from zero.
    function automatic longint round_half_away(input longint s, input longint d);
        longint mag, q;
        mag = (s < 0) ? -s : s;
        q   = (mag + d / 2) / d;
        return (s < 0) ? -q : q;
    endfunction

    // Triangular weighted average centered at window age ctr, ages clamped to the path.
    function automatic path_point_t smoothed_point(input int r, input int ctr, input logic fin);
        longint      sum_x, sum_y, div, q;
        int          j, age, wt;
        path_point_t pt;
        sum_x = 0;
        sum_y = 0;
        div   = longint'((r + 1) * (r + 1));
        for (j = -r; j <= r; j++) begin
            age = ctr - j;
            wt  = r + 1 - ((j < 0) ? -j : j);
            if (age > path_fill - 1)
                age = path_fill - 1;
            if (age < 0)
                age = 0;
            sum_x += longint'(win_x[age]) * wt;
            sum_y += longint'(win_y[age]) * wt;
        end
        q       = round_half_away(sum_x, div);
        pt.x    = q[COORD_W-1:0];
        q       = round_half_away(sum_y, div);
        pt.y    = q[COORD_W-1:0];
        pt.last = fin;
        return pt;
    endfunction

    // Mix of extremes, values near zero and full-range random coordinates.
    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return '0;
            3: return '1;
            4: return COORD_W'($signed($urandom_range(0, 1023)) - 512);
            default: return COORD_W'($urandom());
        endcase
    endfunction

    task automatic push_point(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                              input logic last);
        path_point_t pt;
        pt.x    = px;
        pt.y    = py;
        pt.last = last;
        point_feed_q.push_back(pt);
        fed_count++;
    endtask

    // Hold off until every point is taken and every smoothed point is back, then let the
    // block drain any point that yields nothing.
    task automatic settle_idle();
        while (fed_count != taken_count || smooth_due_q.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_radius(input logic [RADIUS_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        radius_now   = val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Driver: run the predictor on each accepted transaction, then offer the next point
    // in bursts of random length separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            burst_left  = 0;
            gap_left    = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                taken_count++;
                r_eff = (radius_now > MAX_R) ? MAX_R : radius_now;
                // Shift the new point into the window, newest at age 0.
                for (i = WIN_DEPTH - 1; i > 0; i--) begin
                    win_x[i] = win_x[i-1];
                    win_y[i] = win_y[i-1];
                end
                win_x[0] = s_tdata[COORD_W-1:0];
                win_y[0] = s_tdata[2*COORD_W-1:COORD_W];
                if (path_fill < WIN_DEPTH)
                    path_fill++;
                if (s_tlast) begin
                    // Flush every point still owed by the path, oldest first; the newest
                    // one closes the path. Short paths flush all they have.
                    top_c = (path_fill - 1 < r_eff) ? path_fill - 1 : r_eff;
                    for (c = top_c; c >= 0; c--)
                        smooth_due_q.push_back(smoothed_point(r_eff, c, c == 0));
                    path_fill = 0;
                end else if (path_fill >= r_eff + 1) begin
                    smooth_due_q.push_back(smoothed_point(r_eff, r_eff, 1'b0));
                end
            end
            // Only touch the bus once the current transaction has gone.
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (point_feed_q.size() > 0) begin
                    next_pt   = point_feed_q.pop_front();
                    s_tdata  <= {next_pt.y, next_pt.x};
                    s_tlast  <= next_pt.last;
                    s_tvalid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0) begin
                        // Start a new burst; some bursts are long and back-to-back.
                        burst_left = $urandom_range(1, 12);
                        if ($urandom_range(0, 3) == 0) begin
                            burst_left = $urandom_range(20, 40);
                            gap_left   = 0;
                        end else begin
                            gap_left = $urandom_range(1, 50);
                        end
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted smoothed point against the oldest one owed, then pick
    // the next m_tready from the stall pattern or the one long hold-off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left  = 0;
            seg_left   = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (smooth_due_q.size() == 0) begin
                    $display("%0t: unexpected smoothed point x=%h y=%h last=%b", $time,
                             m_tdata[COORD_W-1:0], m_tdata[2*COORD_W-1:COORD_W], m_tlast);
                    fail_count++;
                end else begin
                    due_pt = smooth_due_q.pop_front();
                    if (m_tdata[COORD_W-1:0] !== due_pt.x ||
                        m_tdata[2*COORD_W-1:COORD_W] !== due_pt.y ||
                        m_tlast !== due_pt.last) begin
                        $display(
                            "%0t: mismatch: expected x=%h y=%h last=%b, got x=%h y=%h last=%b",
                            $time, due_pt.x, due_pt.y, due_pt.last,
                            m_tdata[COORD_W-1:0], m_tdata[2*COORD_W-1:COORD_W], m_tlast);
                        fail_count++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_req && !hold_done) begin
                // Stall for a long stretch so the block fills and pushes back.
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
                m_tready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    rx_mode  = rx_mode_t'($urandom_range(0, 2));
                    seg_left = $urandom_range(10, 150);
                end
                seg_left--;
                case (rx_mode)
                    RX_OPEN:    m_tready <= 1'b1;
                    RX_COIN:    m_tready <= ($urandom_range(0, 1) == 1);
                    RX_TRICKLE: m_tready <= ($urandom_range(0, 7) == 0);
                    default:    m_tready <= 1'b1;
                endcase
            end
        end
    end

    // Stimulus: directed paths, then random phases, each under its own radius.
    initial begin
        int phase, target, path_len, k, r_sel;
        bit cut;

        for (i = 0; i < WIN_DEPTH; i++) begin
            win_x[i] = '0;
            win_y[i] = '0;
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset radius: a one-point path, a path whose middle point rounds a tie away
        // from zero in both signs, and a path of extremes.
        push_point(COORD_MAX, COORD_MIN, 1'b1);
        push_point('0, '0, 1'b0);
        push_point(COORD_W'(1), '1, 1'b0);
        push_point('0, '0, 1'b1);
        push_point(COORD_MAX, COORD_MAX, 1'b0);
        push_point(COORD_MAX, COORD_MAX, 1'b0);
        push_point(COORD_MIN, COORD_MIN, 1'b0);
        push_point(COORD_MIN, COORD_MIN, 1'b1);
        settle_idle();

        // Zero radius: every point comes back as is.
        write_radius(RADIUS_W'(0));
        push_point('1, COORD_W'(1), 1'b0);
        push_point(COORD_MIN, COORD_MAX, 1'b1);
        settle_idle();

        // Widest radius: a path shorter than the kernel, then one just past r+1 points.
        write_radius(RADIUS_W'(MAX_R));
        push_point(COORD_MAX, COORD_MIN, 1'b0);
        push_point('0, '1, 1'b0);
        push_point(COORD_MIN, COORD_MAX, 1'b1);
        for (k = 0; k < 9; k++)
            push_point(k[0] ? COORD_MIN : COORD_MAX, k[0] ? COORD_MAX : COORD_MIN, k == 8);

        // Random phases. A phase may stop mid-path so the next radius takes over there.
        target = fed_count + RANDOM_ITEMS;
        phase  = 0;
        while (fed_count < target) begin
            settle_idle();
            case (phase)
                0:       r_sel = 0;
                1:       r_sel = MAX_R;
                default: r_sel = $urandom_range(0, MAX_R);
            endcase
            write_radius(RADIUS_W'(r_sel));
            if (phase == 2)
                hold_req <= 1'b1;
            k = fed_count + $urandom_range(30, 70);
            while (fed_count < k) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3:          path_len = $urandom_range(1, r_sel + 1);
                    4, 5, 6, 7, 8:       path_len = $urandom_range(r_sel + 2, 2*r_sel + 8);
                    default:             path_len = $urandom_range(20, 40);
                endcase
                cut = (fed_count + path_len >= k) && ($urandom_range(0, 2) == 0);
                for (i = 0; i < path_len; i++)
                    push_point(rand_coord(), rand_coord(), (i == path_len - 1) && !cut);
            end
            phase++;
        end

        settle_idle();
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

endmodule
